>>> rtl/slm_pkg.sv
// Shared constants and controller/datapath interface types for the sorted list merger.
package slm_pkg;

    localparam int DEPTH  = 32;
    localparam int WORD_W = 32;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [1:0] ACT_MERGE       = 2'd2;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
        logic emit_empty;
    } slm_cmd_t;

    typedef struct packed {
        logic both_empty;
        logic slot_free;
        logic last_take;
    } slm_stat_t;

endpackage

>>> rtl/slm_ctrl.sv
// Controller state machine that sequences loads and merges of the sorted list merger.
module slm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [1:0]       action,
    output logic             s_tready,
    input  slm_pkg::slm_stat_t stat,
    output slm_pkg::slm_cmd_t  cmd
);
    import slm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (action)
                        ACT_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        ACT_LOAD_SECOND: cmd.load_second = 1'b1;
                        ACT_MERGE:       state_next = stat.both_empty ? ST_EMPTY : ST_MERGE;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (stat.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.last_take)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/slm_datapath.sv
// Datapath of the sorted list merger: list memories, counts, head pointers and output register.
module slm_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  slm_pkg::slm_cmd_t          cmd,
    output slm_pkg::slm_stat_t         stat,
    input  logic [slm_pkg::WORD_W-1:0] word,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [slm_pkg::WORD_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [2:0]                 m_tuser
);
    import slm_pkg::*;

    logic [WORD_W-1:0] mem_a [0:DEPTH-1];
    logic [WORD_W-1:0] mem_b [0:DEPTH-1];

    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          ovf_reg, ovf_next;

    logic          take_first;
    logic [CW-1:0] i_after;
    logic [CW-1:0] j_after;
    logic          last_take;
    logic          full_a;
    logic          full_b;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_src_reg;
    logic              out_last_reg;
    logic              out_empty_reg;
    logic              out_drop_reg;

    assign full_a = (cnt_a_reg == CW'(DEPTH));
    assign full_b = (cnt_b_reg == CW'(DEPTH));

    // The first head wins only when it is strictly smaller, so equal heads favor the second list.
    assign take_first = (i_reg < cnt_a_reg) &&
                        ((j_reg >= cnt_b_reg) || ($signed(rd_a_reg) < $signed(rd_b_reg)));
    assign i_after    = i_reg + CW'(take_first);
    assign j_after    = j_reg + CW'(!take_first);
    assign last_take  = (i_after == cnt_a_reg) && (j_after == cnt_b_reg);

    assign stat.both_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign stat.slot_free  = !out_valid_reg || m_tready;
    assign stat.last_take  = last_take;

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg;
        if (cmd.load_first)
        begin
            if (full_a)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_a_next = cnt_a_reg + CW'(1);
            end
        end
        if (cmd.load_second)
        begin
            if (full_b)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_b_next = cnt_b_reg + CW'(1);
            end
        end
        if (cmd.step)
        begin
            if (last_take)
            begin
                cnt_a_next = '0;
                cnt_b_next = '0;
                i_next     = '0;
                j_next     = '0;
            end
            else
            begin
                i_next = i_after;
                j_next = j_after;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step || cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // List memories: one write port and one registered read port each, read at the next head.
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && !full_a)
        begin
            mem_a[cnt_a_reg[AW-1:0]] <= word;
        end
        if (cmd.load_second && !full_b)
        begin
            mem_b[cnt_b_reg[AW-1:0]] <= word;
        end
        rd_a_reg <= mem_a[i_next[AW-1:0]];
        rd_b_reg <= mem_b[j_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_word_reg  <= take_first ? rd_a_reg : rd_b_reg;
            out_src_reg   <= !take_first;
            out_last_reg  <= last_take;
            out_empty_reg <= 1'b0;
            out_drop_reg  <= ovf_reg;
        end
        else if (cmd.emit_empty)
        begin
            out_word_reg  <= '0;
            out_src_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
            out_drop_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_drop_reg, out_empty_reg, out_src_reg};

endmodule

>>> rtl/sorted_list_merger.sv
// Top level of the sorted list merger: two-list load and ascending merge unit.
//
//  Channel | Direction | tdata                  | tuser                                  | tlast
//  s_*     | in        | [31:0] word (signed)   | [1:0] action                           | -
//  m_*     | out       | [31:0] merged_word     | [0] from_second [1] empty_merge        | last_word
//          |           |                        | [2] dropped_loads                      |
//
// A load beat (action 0 or 1) appends its word to the chosen list; a word for a list that
// already holds 32 entries is dropped and sets a sticky dropped flag. Action 3 is accepted and
// ignored. Once a merge beat is accepted, one result is emitted per cycle while the output is
// not stalled, na + nb results in total, or a single empty result when both lists are empty;
// the pace is set by the single read port of each list memory, whose registered head is refreshed
// at the pointer of the list just consumed. While a merge is emitting, the input side is not ready.
// Backpressure on the output holds the result register and pauses the merge without loss.
// The asynchronous active-low reset empties both lists and clears the dropped flag; list
// contents are not cleared, since only entries below the counts are ever read.
module sorted_list_merger (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] merged_word
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [0] from_second, [1] empty_merge, [2] dropped_loads
);
    import slm_pkg::*;

    slm_cmd_t  cmd;
    slm_stat_t stat;

    // The controller decodes the action and paces the merge; all list storage sits in the datapath.
    slm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .word     (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/slm_checker.sv
// Port-level assertion checker for the sorted list merger and its bind statement.
module slm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);
    import slm_pkg::*;

    logic seen_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_drop_reg <= 1'b0;
        end
        else if (m_tvalid && m_tuser[2])
        begin
            seen_drop_reg <= 1'b1;
        end
    end

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output beat changed");

    // An empty merge result is a lone, zero, final beat.
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 32'd0) && !m_tuser[0])
        else $error("malformed empty merge result");

    // The dropped flag never falls once it has been shown.
    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_drop_reg |-> m_tuser[2])
        else $error("dropped flag cleared");

    // Accepting a merge beat blocks the input side while the merge runs.
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_MERGE) |=> !s_tready)
        else $error("input ready right after a merge beat");

endmodule

bind sorted_list_merger slm_checker u_slm_checker (.*);

>>> bench/tb_sorted_list_merger.sv
// Self-checking testbench for the sorted list merger: random load and merge beats, checked results.
module tb_sorted_list_merger;

    import slm_pkg::*;

    // Action code 3 is not defined by the package; the block accepts and ignores it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 500;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [31:0] word_t;
    typedef word_t word_q_t[$];

    localparam word_t WORD_MIN = 32'h8000_0000;
    localparam word_t WORD_MAX = 32'h7fff_ffff;

    // One input beat as the driver presents it.
    typedef struct packed {
        logic [1:0] action;
        word_t      word;
    } merger_cmd_t;

    // One output beat, field by field, as the predictor expects it.
    typedef struct packed {
        word_t merged_word;
        logic  from_second;
        logic  last_word;
        logic  empty_merge;
        logic  dropped_loads;
    } merger_beat_t;

    // Kinds of word content used when building lists.
    typedef enum {
        MIX_WIDE,
        MIX_TIES,
        MIX_EDGES
    } word_mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    sorted_list_merger DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Beats still to be sent, and merged words still owed by the block.
    merger_cmd_t  pending_items[$];
    merger_beat_t merged_words_due[$];

    // Private copy of the block's list state, updated as each beat is accepted.
    word_t first_words[DEPTH];
    word_t second_words[DEPTH];
    int    first_len = 0;
    int    second_len = 0;
    logic  dropped_seen = 1'b0;

    int   items_made = 0;
    int   items_taken = 0;
    int   mismatch_count = 0;
    logic s_fire = 1'b0;
    int   feed_gap = 0;
    int   hold_left = 0;
    // While set, neither side idles, so the block runs at full rate for a stretch.
    bit   steady_run = 1'b0;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted beat to the list state and queues the results a merge produces.
    // The first head is taken only when strictly below the second head, so ties go to the
    // second list first.
    task automatic predict_merger(input merger_cmd_t cmd);
        merger_beat_t beat;
        int i;
        int j;
        int total;
        i = 0;
        j = 0;
        case (cmd.action)
            ACT_LOAD_FIRST:
            begin
                if (first_len < DEPTH)
                begin
                    first_words[first_len] = cmd.word;
                    first_len++;
                end
                else
                    dropped_seen = 1'b1;
            end
            ACT_LOAD_SECOND:
            begin
                if (second_len < DEPTH)
                begin
                    second_words[second_len] = cmd.word;
                    second_len++;
                end
                else
                    dropped_seen = 1'b1;
            end
            ACT_MERGE:
            begin
                total = first_len + second_len;
                if (total == 0)
                begin
                    beat.merged_word   = '0;
                    beat.from_second   = 1'b0;
                    beat.last_word     = 1'b1;
                    beat.empty_merge   = 1'b1;
                    beat.dropped_loads = dropped_seen;
                    merged_words_due.push_back(beat);
                end
                while (i + j < total)
                begin
                    if (i < first_len &&
                        (j >= second_len || first_words[i] < second_words[j]))
                    begin
                        beat.merged_word = first_words[i];
                        beat.from_second = 1'b0;
                        i++;
                    end
                    else
                    begin
                        beat.merged_word = second_words[j];
                        beat.from_second = 1'b1;
                        j++;
                    end
                    beat.last_word     = (i + j == total);
                    beat.empty_merge   = 1'b0;
                    beat.dropped_loads = dropped_seen;
                    merged_words_due.push_back(beat);
                end
                first_len  = 0;
                second_len = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Input side. A new beat is presented at a falling edge once the previous one has been taken
    // and the chosen gap has run out.
    always @(negedge clk)
    begin : feeder
        merger_cmd_t cmd;
        if (rst_n)
        begin
            if (!s_tvalid || s_fire)
            begin
                if (feed_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    cmd = pending_items.pop_front();
                    s_tdata  <= cmd.word;
                    s_tuser  <= cmd.action;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        steady_run = !steady_run;
                    feed_gap <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
            // Output side: random stalls of the same shape.
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold_left <= pick_gap();
            end
        end
    end

    // Both handshakes are sampled at the rising edge. An accepted input beat is predicted first,
    // then an accepted result is compared with the oldest word still owed.
    always @(posedge clk)
    begin : watcher
        merger_cmd_t  cmd;
        merger_beat_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            cmd.action = s_tuser;
            cmd.word   = s_tdata;
            predict_merger(cmd);
            items_taken++;
            s_fire <= 1'b1;
        end
        else
            s_fire <= 1'b0;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (merged_words_due.size() == 0)
            begin
                $error("unexpected result beat: merged_word %0d", $signed(m_tdata));
                mismatch_count++;
            end
            else
            begin
                want = merged_words_due.pop_front();
                if (m_tdata !== want.merged_word)
                begin
                    $error("merged_word: expected %0d, got %0d", want.merged_word,
                           $signed(m_tdata));
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.from_second)
                begin
                    $error("from_second: expected %0d, got %0d", want.from_second, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last_word)
                begin
                    $error("last_word: expected %0d, got %0d", want.last_word, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.empty_merge)
                begin
                    $error("empty_merge: expected %0d, got %0d", want.empty_merge, m_tuser[1]);
                    mismatch_count++;
                end
                if (m_tuser[2] !== want.dropped_loads)
                begin
                    $error("dropped_loads: expected %0d, got %0d", want.dropped_loads,
                           m_tuser[2]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic add_item(input logic [1:0] action, input word_t word);
        merger_cmd_t cmd;
        cmd.action = action;
        cmd.word   = word;
        pending_items.push_back(cmd);
        items_made++;
    endtask

    function automatic word_t pick_word(input word_mix_t mix);
        word_t edges[7];
        edges = '{WORD_MIN, WORD_MIN + 1, -1, 0, 1, WORD_MAX - 1, WORD_MAX};
        case (mix)
            MIX_TIES:  return $signed($urandom_range(0, 6)) - 3;
            MIX_EDGES: return edges[$urandom_range(0, 6)];
            default:   return $urandom;
        endcase
    endfunction

    // Builds a list of n words; an ordered list is kept ascending by sorted insertion.
    task automatic make_list(input int n, input word_mix_t mix, input bit ordered,
                             output word_q_t lst);
        word_t v;
        int    pos;
        lst = {};
        for (int k = 0; k < n; k++)
        begin
            v   = pick_word(mix);
            pos = lst.size();
            if (ordered)
                while (pos > 0 && lst[pos - 1] > v)
                    pos--;
            lst.insert(pos, v);
        end
    endtask

    // Sends both lists with the loads interleaved at random, sprinkled with ignored beats.
    task automatic queue_lists(input word_q_t a, input word_q_t b);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size())
        begin
            if ($urandom_range(0, 19) == 0)
                add_item(ACT_UNUSED, $urandom);
            if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 1))
            begin
                add_item(ACT_LOAD_FIRST, a[ia]);
                ia++;
            end
            else
            begin
                add_item(ACT_LOAD_SECOND, b[ib]);
                ib++;
            end
        end
    endtask

    // Mostly short lists, a few long ones up to the full depth.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 95)
            return $urandom_range(7, 16);
        return $urandom_range(17, DEPTH);
    endfunction

    initial
    begin : stimulus
        word_q_t   list_a;
        word_q_t   list_b;
        word_mix_t mix;
        bit        overflow_done;
        overflow_done = 1'b0;

        // Directed part. A merge with both lists empty comes first.
        add_item(ACT_MERGE, $urandom);
        // Extreme words on both sides, with equal heads at the minimum, at zero and at five.
        add_item(ACT_LOAD_FIRST, WORD_MIN);
        add_item(ACT_LOAD_SECOND, WORD_MIN);
        add_item(ACT_LOAD_FIRST, -1);
        add_item(ACT_LOAD_SECOND, 0);
        add_item(ACT_LOAD_FIRST, 0);
        add_item(ACT_UNUSED, 32'hffff_ffff);
        add_item(ACT_LOAD_FIRST, 5);
        add_item(ACT_LOAD_SECOND, 5);
        add_item(ACT_LOAD_SECOND, 7);
        add_item(ACT_LOAD_FIRST, WORD_MAX);
        add_item(ACT_MERGE, 32'hffff_ffff);
        // Only the first list filled, then only the second.
        add_item(ACT_LOAD_FIRST, 3);
        add_item(ACT_MERGE, 0);
        add_item(ACT_LOAD_SECOND, WORD_MAX);
        add_item(ACT_LOAD_SECOND, 1);
        add_item(ACT_MERGE, $urandom);
        // An ignored beat on its own must not disturb an empty merge.
        add_item(ACT_UNUSED, 0);
        add_item(ACT_MERGE, $urandom);

        // Random part: well-formed ascending lists for the most part, some unordered ones.
        // Overflow is sticky, so both lists are overfilled only late in the run.
        while (items_made < ITEM_TARGET)
        begin
            mix = word_mix_t'($urandom_range(0, 2));
            if (!overflow_done && items_made > 380)
            begin
                make_list(DEPTH + 2, mix, 1'b1, list_a);
                make_list(DEPTH + 1, mix, 1'b1, list_b);
                overflow_done = 1'b1;
            end
            else
            begin
                make_list(pick_len(), mix, $urandom_range(0, 9) != 0, list_a);
                make_list(pick_len(), mix, $urandom_range(0, 9) != 0, list_b);
            end
            queue_lists(list_a, list_b);
            add_item(ACT_MERGE, $urandom);
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_made || merged_words_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && merged_words_due.size() == 0)
            $display("tb_sorted_list_merger: PASS");
        else
            $display("tb_sorted_list_merger: FAIL");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("tb_sorted_list_merger: FAIL");
        $finish;
    end

endmodule
